// ===== rtl/bipcf_pkg.sv =====
// Shared types, constants and helper functions for the bitstream id patch / CRC fix block.
// Used by bipcf_scan and bitstream_id_patch_crc_fix; depends on nothing else.
package bipcf_pkg;

   localparam int POS_BITS_DEFAULT = 24;

   localparam logic [15:0] CRC_POLY          = 16'h8005;
   localparam logic [7:0]  FAMILY_LONG       = 8'h41;
   localparam logic [7:0]  FAMILY_PATCH      = 8'h01;
   localparam logic [7:0]  ID_BYTE_ONE       = 8'h11;
   localparam logic [7:0]  ID_BYTE_THREE     = 8'h43;
   localparam logic [7:0]  CODE_SMALL        = 8'h10;
   localparam logic [7:0]  CODE_MEDIUM       = 8'h20;
   localparam logic [7:0]  CODE_LARGE        = 8'h30;
   localparam logic [7:0]  CMD_INCR          = 8'h82;
   localparam logic [7:0]  CMD_INCR_ARG      = 8'h91;
   localparam logic [7:0]  BYTE_ONES         = 8'hFF;
   localparam logic [7:0]  MASK_SKIP         = 8'hFC;
   localparam logic [7:0]  MASK_IDLE         = 8'hFF;

   localparam logic [13:0] FRAME_CNT_MAX     = 14'h3FFF;

   localparam logic [0:7][7:0] PAT_PREAMBLE =
      {8'hFF, 8'hFF, 8'hBD, 8'hB3, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
   localparam logic [0:7][7:0] PAT_DONE =
      {8'h5E, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
   localparam logic [0:3][7:0] PAT_RESET_CRC = {8'h3B, 8'h00, 8'h00, 8'h00};
   localparam logic [0:3][7:0] PAT_VERIFY_ID = {8'hE2, 8'h00, 8'h00, 8'h00};

   typedef enum logic [1:0] {
      RUN_ACTIVE,
      RUN_DONE,
      RUN_ERROR
   } run_state_type;

   typedef enum logic [1:0] {
      STATUS_SEARCH = 2'd0,
      STATUS_KNOWN  = 2'd1,
      STATUS_DONE   = 2'd2,
      STATUS_ERROR  = 2'd3
   } scan_status_type;

   typedef struct packed {
      logic [0:7][7:0] bytes;
      logic [3:0]      count;
      logic [2:0]      first;
      logic            last;
      scan_status_type status;
      logic [15:0]     crc;
      logic            crc_valid;
      logic [13:0]     frames;
   } scan_out_type;

   function automatic logic [13:0] geo_frames(input logic [1:0] size);
      case (size)
         2'd1:    geo_frames = 14'd7562;
         2'd2:    geo_frames = 14'd9470;
         2'd3:    geo_frames = 14'd13294;
         default: geo_frames = 14'd0;
      endcase
   endfunction

   // frame length in bytes (bits / 8)
   function automatic logic [7:0] geo_bytes(input logic [1:0] size);
      case (size)
         2'd1:    geo_bytes = 8'(592 / 8);
         2'd2:    geo_bytes = 8'(848 / 8);
         2'd3:    geo_bytes = 8'(1136 / 8);
         default: geo_bytes = 8'd0;
      endcase
   endfunction

   function automatic logic [1:0] id_size(input logic [7:0] b4, input logic [7:0] b5,
                                          input logic [7:0] b6, input logic [7:0] b7);
      id_size = 2'd0;
      if ((b4 inside {FAMILY_PATCH, FAMILY_LONG}) && b5 == ID_BYTE_ONE &&
          b7 == ID_BYTE_THREE) begin
         case (b6)
            CODE_SMALL:  id_size = 2'd1;
            CODE_MEDIUM: id_size = 2'd2;
            CODE_LARGE:  id_size = 2'd3;
            default:     id_size = 2'd0;
         endcase
      end
   endfunction

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      crc_step = c;
   endfunction

endpackage

// ===== rtl/bipcf_scan.sv =====
// Window, pattern scan, CRC tracking and id patch state for one input byte per cycle while accept is high.
// Depends on bipcf_pkg; instantiated by bitstream_id_patch_crc_fix.
module bipcf_scan #(
   parameter int POSITION_BITS = bipcf_pkg::POS_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              data,
   input  logic                    last,
   input  logic                    patch_enable,
   output bipcf_pkg::scan_out_type result
);
   import bipcf_pkg::*;

   logic [0:7][7:0]          win_ff, win_in;
   logic [3:0]               fill_ff, fill_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] nxt_ff, nxt_in;
   logic                     pre_ff, pre_in;
   logic [1:0]               dev_ff, dev_in;
   logic                     idp_ff, idp_in;
   logic [15:0]              crc_ff, crc_in;
   logic                     cbs_ff, cbs_in;
   logic [13:0]              fc_ff, fc_in;
   logic [7:0]               fbc_ff, fbc_in;
   logic [7:0]               mask_ff, mask_in;
   run_state_type            run_ff, run_in;
   logic                     ov0_valid_ff, ov0_valid_in;
   logic                     ov1_valid_ff, ov1_valid_in;
   logic [7:0]               ov0_byte_ff, ov0_byte_in;
   logic [7:0]               ov1_byte_ff, ov1_byte_in;

   logic [13:0]              frames;
   logic [1:0]               size;
   logic                     stop;
   logic                     inc_hit;
   logic [15:0]              crc_rep;
   logic                     crc_rep_valid;
   logic [0:7][7:0]          emit;

   always_comb begin
      win_in       = {win_ff[1:7], data};
      ov0_valid_in = ov1_valid_ff;
      ov0_byte_in  = ov1_byte_ff;
      ov1_valid_in = 1'b0;
      ov1_byte_in  = 8'h00;
      pos_in       = pos_ff + POSITION_BITS'(1);
      fill_in      = (fill_ff < 4'd8) ? fill_ff + 4'd1 : fill_ff;
      nxt_in       = nxt_ff;
      pre_in       = pre_ff;
      dev_in       = dev_ff;
      idp_in       = idp_ff;
      crc_in       = crc_ff;
      cbs_in       = cbs_ff;
      fc_in        = fc_ff;
      fbc_in       = fbc_ff;
      mask_in      = mask_ff;
      run_in       = run_ff;
      frames       = geo_frames(dev_ff);
      size         = 2'd0;
      stop         = 1'b0;
      inc_hit      = 1'b0;
      crc_rep      = 16'h0000;
      crc_rep_valid = 1'b0;

      if (run_ff == RUN_ACTIVE) begin
         if (!pre_ff && win_in == PAT_PREAMBLE) begin
            pre_in = 1'b1;
         end else if (dev_ff == 2'd0) begin
            if (win_in[0:3] == PAT_RESET_CRC) begin
               crc_in = 16'h0000;
            end
            if (win_in[0:3] == PAT_VERIFY_ID) begin
               size = id_size(win_in[4], win_in[5], win_in[6], win_in[7]);
               if (size == 2'd0) begin
                  run_in = RUN_ERROR;
                  stop   = 1'b1;
               end else begin
                  dev_in = size;
                  frames = geo_frames(size);
                  if (patch_enable && win_in[4] == FAMILY_LONG) begin
                     win_in[4] = FAMILY_PATCH;
                     idp_in    = 1'b1;
                  end
                  cbs_in = 1'b0;
               end
            end
         end

         if (!stop) begin
            inc_hit = (win_in[0:3] == {CMD_INCR, CMD_INCR_ARG, {2'b00, frames[13:8]},
                                       frames[7:0]});
            if (nxt_ff != '0 && pos_in == nxt_ff) begin
               mask_in = MASK_SKIP;
               nxt_in  = pos_in + POSITION_BITS'(fbc_ff) + POSITION_BITS'(3);
            end else if (inc_hit) begin
               fbc_in = geo_bytes(dev_in);
               nxt_in = pos_in + POSITION_BITS'(fbc_in) + POSITION_BITS'(4);
            end

            if (win_in == PAT_DONE) begin
               run_in = RUN_DONE;
            end else begin
               if (dev_in != 2'd0 && mask_in[0]) begin
                  crc_in = crc_step(crc_in, win_in[0]);
                  cbs_in = 1'b1;
               end else if (win_in[2] == BYTE_ONES && cbs_in) begin
                  fc_in = (fc_ff < FRAME_CNT_MAX) ? fc_ff + 14'd1 : fc_ff;
                  if (patch_enable && idp_in && fc_in == 14'd1) begin
                     ov0_valid_in = 1'b1;
                     ov0_byte_in  = crc_in[15:8];
                     ov1_valid_in = 1'b1;
                     ov1_byte_in  = crc_in[7:0];
                  end
                  crc_rep       = crc_in;
                  crc_rep_valid = 1'b1;
                  if (fc_in != frames) begin
                     crc_in = 16'h0000;
                     cbs_in = 1'b0;
                  end
               end
               mask_in = {1'b1, mask_in[7:1]};
            end
         end
      end

      emit = win_in;
      if (ov0_valid_in) begin
         emit[0] = ov0_byte_in;
      end
      if (ov1_valid_in) begin
         emit[1] = ov1_byte_in;
      end

      result.bytes     = emit;
      result.last      = last;
      result.crc       = crc_rep;
      result.crc_valid = crc_rep_valid;
      result.frames    = fc_in;
      if (last) begin
         result.count = fill_in;
         result.first = 3'(4'd8 - fill_in);
      end else begin
         result.count = (fill_in == 4'd8) ? 4'd1 : 4'd0;
         result.first = 3'd0;
      end
      case (run_in)
         RUN_DONE:  result.status = STATUS_DONE;
         RUN_ERROR: result.status = STATUS_ERROR;
         default:   result.status = (dev_in != 2'd0) ? STATUS_KNOWN : STATUS_SEARCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last)) begin
         win_ff       <= '0;
         fill_ff      <= 4'd0;
         pos_ff       <= '0;
         nxt_ff       <= '0;
         pre_ff       <= 1'b0;
         dev_ff       <= 2'd0;
         idp_ff       <= 1'b0;
         crc_ff       <= 16'h0000;
         cbs_ff       <= 1'b0;
         fc_ff        <= 14'd0;
         fbc_ff       <= 8'd0;
         mask_ff      <= MASK_IDLE;
         run_ff       <= RUN_ACTIVE;
         ov0_valid_ff <= 1'b0;
         ov1_valid_ff <= 1'b0;
         ov0_byte_ff  <= 8'h00;
         ov1_byte_ff  <= 8'h00;
      end else if (accept) begin
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         nxt_ff       <= nxt_in;
         pre_ff       <= pre_in;
         dev_ff       <= dev_in;
         idp_ff       <= idp_in;
         crc_ff       <= crc_in;
         cbs_ff       <= cbs_in;
         fc_ff        <= fc_in;
         fbc_ff       <= fbc_in;
         mask_ff      <= mask_in;
         run_ff       <= run_in;
         ov0_valid_ff <= ov0_valid_in;
         ov1_valid_ff <= ov1_valid_in;
         ov0_byte_ff  <= ov0_byte_in;
         ov1_byte_ff  <= ov1_byte_in;
      end
   end

endmodule

// ===== rtl/bitstream_id_patch_crc_fix.sv =====
// Top level: stream handshakes, patch-enable register and the output / flush buffer.
// Depends on bipcf_pkg and bipcf_scan.
//
//   channel   dir  handshake              payload
//   req       in   req_tvalid/req_tready  tdata[7:0] data_byte, tlast is_last
//   rsp       out  rsp_tvalid/rsp_tready  tdata out_byte/frame_crc/frames_seen,
//                                         tlast out_last, tuser scan_status/crc_valid
//   csr       in   csr_valid/csr_ready    csr_data patch_enable
//
// One byte per cycle is accepted while req_tready is high; its result is registered.
// A byte with tlast flushes the 8-byte window: up to 8 results leave one at a time from
// the single-read output buffer, and no request is taken until the last is taken.
// The first 7 bytes of a run produce no result (window filling) unless one has tlast.
// Reset is synchronous; it empties the window and sets patch_enable.
module bitstream_id_patch_crc_fix #(
   parameter int POSITION_BITS = bipcf_pkg::POS_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [23:8] frame_crc, [37:24] frames_seen
   output logic        rsp_tlast,
   output logic [2:0]  rsp_tuser,   // [1:0] scan_status, [2] frame_crc_valid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import bipcf_pkg::*;

   logic            patch_ff;
   scan_out_type    scan;
   logic            accept;
   logic            pop;

   logic [0:7][7:0] obuf_ff;
   logic [3:0]      rem_ff;
   logic [2:0]      idx_ff;
   logic            last_ff;
   logic            first_ff;
   scan_status_type status_ff;
   logic [15:0]     crc_ff;
   logic            crcv_ff;
   logic [13:0]     frames_ff;
   logic            crc_flag;

   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (rem_ff == 4'd0) || (rem_ff == 4'd1 && rsp_tready);
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         patch_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         patch_ff <= csr_data;
      end
   end

   bipcf_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data         (req_tdata),
      .last         (req_tlast),
      .patch_enable (patch_ff),
      .result       (scan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= 4'd0;
         idx_ff   <= 3'd0;
         first_ff <= 1'b0;
      end else if (accept && scan.count != 4'd0) begin
         rem_ff   <= scan.count;
         idx_ff   <= scan.first;
         first_ff <= 1'b1;
      end else if (pop) begin
         rem_ff   <= rem_ff - 4'd1;
         idx_ff   <= idx_ff + 3'd1;
         first_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && scan.count != 4'd0) begin
         obuf_ff   <= scan.bytes;
         last_ff   <= scan.last;
         status_ff <= scan.status;
         crc_ff    <= scan.crc;
         crcv_ff   <= scan.crc_valid;
         frames_ff <= scan.frames;
      end
   end

   assign crc_flag   = first_ff && crcv_ff;
   assign rsp_tvalid = (rem_ff != 4'd0);
   assign rsp_tlast  = last_ff && (rem_ff == 4'd1);
   assign rsp_tdata  = {2'b00, frames_ff, (crc_flag ? crc_ff : 16'h0000), obuf_ff[idx_ff]};
   assign rsp_tuser  = {crc_flag, status_ff};

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 4'd8)
      else $error("output count beyond window depth");

   a_last_flushes: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> rsp_tvalid && rem_ff >= 4'd1)
      else $error("last request produced no flush");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      accept && !req_tlast |=> rem_ff <= 4'd1)
      else $error("ordinary request produced more than one result");

   a_flush_continues: assert property (@(posedge clock) disable iff (reset)
      pop && rem_ff > 4'd2 |=> rsp_tvalid && !req_tready)
      else $error("flush interrupted");

endmodule

// ===== tb/bitstream_scan_checker.sv =====
// Response checker for bitstream_id_patch_crc_fix: follows the request, response and CSR
// channels, keeps its own copy of the byte window, frame CRC and scan state, and compares
// every response against the predicted one. Depends on bipcf_pkg for encodings.
module bitstream_scan_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int          mismatch_count,
   output int          bytes_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import bipcf_pkg::*;

   typedef struct {
      logic [7:0]      data;
      logic            last;
      scan_status_type status;
      logic [15:0]     crc;
      logic            crc_valid;
      logic [13:0]     frames;
   } out_beat_type;

   localparam logic [0:3][13:0] FRAME_TOTAL = {14'd0, 14'd7562, 14'd9470, 14'd13294};
   localparam logic [0:3][10:0] FRAME_BITS  = {11'd0, 11'd592, 11'd848, 11'd1136};
   localparam logic [0:3][7:0]  SIZE_CODE   = {8'h00, CODE_SMALL, CODE_MEDIUM, CODE_LARGE};

   logic [7:0]    win [8];
   int            fill;
   logic [23:0]   pos;
   logic          sync_found;
   logic [1:0]    dev_size;
   logic          id_fixed;
   logic [15:0]   crc_acc;
   logic          crc_live;
   logic [13:0]   frame_cnt;
   logic [23:0]   check_pos;
   logic [7:0]    frame_len;
   logic [7:0]    skip_mask;
   run_state_type run;
   logic          ovl_on [2];
   logic [7:0]    ovl_val [2];
   logic          patch_en;
   out_beat_type  expected_beats [$];

   function automatic void clear_stream();
      for (int i = 0; i < 8; i++) win[i] = 8'h00;
      fill = 0;
      pos = '0;
      sync_found = 1'b0;
      dev_size = 2'd0;
      id_fixed = 1'b0;
      crc_acc = '0;
      crc_live = 1'b0;
      frame_cnt = '0;
      check_pos = '0;
      frame_len = '0;
      skip_mask = 8'hFF;
      run = RUN_ACTIVE;
      for (int i = 0; i < 2; i++) begin
         ovl_on[i] = 1'b0;
         ovl_val[i] = 8'h00;
      end
   endfunction

   function automatic logic [15:0] crc16_feed(input logic [15:0] c, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0};
         if (fb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function automatic bit head_is(input logic [0:7][7:0] pat, input int n);
      for (int i = 0; i < n; i++)
         if (win[i] != pat[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void scan_window(output logic [15:0] crc_rep, output logic crc_hit);
      logic [13:0]      frames;
      logic [1:0]       sz;
      logic [0:7][7:0]  incr;
      crc_rep = '0;
      crc_hit = 1'b0;
      frames = FRAME_TOTAL[dev_size];
      if (!sync_found && head_is(PAT_PREAMBLE, 8)) begin
         sync_found = 1'b1;
      end else if (dev_size == 2'd0) begin
         if (head_is({PAT_RESET_CRC, 32'h0}, 4)) crc_acc = '0;
         if (head_is({PAT_VERIFY_ID, 32'h0}, 4)) begin
            sz = 2'd0;
            if ((win[4] == FAMILY_PATCH || win[4] == FAMILY_LONG) &&
                win[5] == ID_BYTE_ONE && win[7] == ID_BYTE_THREE) begin
               for (int s = 1; s < 4; s++)
                  if (win[6] == SIZE_CODE[s]) sz = 2'(s);
            end
            if (sz == 2'd0) begin
               run = RUN_ERROR;
               return;
            end
            dev_size = sz;
            frames = FRAME_TOTAL[sz];
            if (patch_en && win[4] == FAMILY_LONG) begin
               win[4] = FAMILY_PATCH;
               id_fixed = 1'b1;
            end
            crc_live = 1'b0;
         end
      end

      incr = {CMD_INCR, CMD_INCR_ARG, 2'b00, frames[13:8], frames[7:0], 32'h0};
      if (check_pos != '0 && pos == check_pos) begin
         skip_mask = MASK_SKIP;
         check_pos = pos + 24'(frame_len) + 24'd3;
      end else if (head_is(incr, 4)) begin
         frame_len = 8'(FRAME_BITS[dev_size] >> 3);
         check_pos = pos + 24'(frame_len) + 24'd4;
      end

      if (head_is(PAT_DONE, 8)) begin
         run = RUN_DONE;
         return;
      end else if (dev_size != 2'd0 && skip_mask[0]) begin
         crc_acc = crc16_feed(crc_acc, win[0]);
         crc_live = 1'b1;
      end else if (win[2] == BYTE_ONES && crc_live) begin
         if (frame_cnt != FRAME_CNT_MAX) frame_cnt = frame_cnt + 14'd1;
         if (patch_en && id_fixed && frame_cnt == 14'd1) begin
            ovl_on[0] = 1'b1;
            ovl_val[0] = crc_acc[15:8];
            ovl_on[1] = 1'b1;
            ovl_val[1] = crc_acc[7:0];
         end
         crc_rep = crc_acc;
         crc_hit = 1'b1;
         if (frame_cnt != frames) begin
            crc_acc = '0;
            crc_live = 1'b0;
         end
      end
      skip_mask = {1'b1, skip_mask[7:1]};
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic last);
      logic [15:0]     crc_rep;
      logic            crc_hit;
      scan_status_type st;
      int              lo;
      int              hi;
      out_beat_type    beat;
      for (int i = 0; i < 7; i++) win[i] = win[i + 1];
      win[7] = b;
      ovl_on[0] = ovl_on[1];
      ovl_val[0] = ovl_val[1];
      ovl_on[1] = 1'b0;
      ovl_val[1] = 8'h00;
      pos = pos + 24'd1;
      if (fill < 8) fill++;

      crc_rep = '0;
      crc_hit = 1'b0;
      if (run == RUN_ACTIVE) scan_window(crc_rep, crc_hit);

      case (run)
         RUN_DONE:  st = STATUS_DONE;
         RUN_ERROR: st = STATUS_ERROR;
         default:   st = (dev_size != 2'd0) ? STATUS_KNOWN : STATUS_SEARCH;
      endcase

      if (last) begin
         lo = 8 - fill;
         hi = 7;
      end else if (fill == 8) begin
         lo = 0;
         hi = 0;
      end else begin
         lo = 8;
         hi = 7;
      end
      for (int i = lo; i <= hi; i++) begin
         beat.data = (i < 2 && ovl_on[i]) ? ovl_val[i] : win[i];
         beat.last = last && i == 7;
         beat.status = st;
         beat.crc = (i == lo && crc_hit) ? crc_rep : 16'h0000;
         beat.crc_valid = i == lo && crc_hit;
         beat.frames = frame_cnt;
         expected_beats.push_back(beat);
      end
      if (last) clear_stream();
   endfunction

   function automatic void flag(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      out_beat_type want;
      out_beat_type got;
      if (reset) begin
         clear_stream();
         patch_en = 1'b1;
         expected_beats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.data = rsp_tdata[7:0];
            got.last = rsp_tlast;
            got.status = scan_status_type'(rsp_tuser[1:0]);
            got.crc = rsp_tdata[23:8];
            got.crc_valid = rsp_tuser[2];
            got.frames = rsp_tdata[37:24];
            if (expected_beats.size() == 0) begin
               flag($sformatf("response with nothing pending: byte=%02h last=%0d", got.data,
                              got.last));
            end else begin
               want = expected_beats.pop_front();
               if (got.data !== want.data || got.last !== want.last ||
                   got.status !== want.status || got.crc !== want.crc ||
                   got.crc_valid !== want.crc_valid || got.frames !== want.frames)
                  flag($sformatf({"mismatch: want byte=%02h last=%0d st=%0d crc=%04h/%0d ",
                                  "frames=%0d, got byte=%02h last=%0d st=%0d crc=%04h/%0d ",
                                  "frames=%0d"},
                                 want.data, want.last, want.status, want.crc,
                                 want.crc_valid, want.frames, got.data, got.last,
                                 got.status, got.crc, got.crc_valid, got.frames));
            end
         end
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tlast);
         if (csr_valid && csr_ready) patch_en = csr_data;
      end
      bytes_outstanding = expected_beats.size();
   end

endmodule

// ===== tb/tb_bitstream_id_patch_crc_fix.sv =====
// Top of the bitstream_id_patch_crc_fix regression: clock, reset, byte stream stimulus
// with random idling on both channels, patch_enable writes and the final verdict.
// Depends on bipcf_pkg, the block itself and bitstream_scan_checker.
module tb_bitstream_id_patch_crc_fix;
   timeunit 1ns;
   timeprecision 1ps;
   import bipcf_pkg::*;

   localparam logic [0:15][7:0] HOT_BYTES = {
      BYTE_ONES, 8'h00, CMD_INCR, CMD_INCR_ARG, PAT_VERIFY_ID[0], FAMILY_LONG, FAMILY_PATCH,
      ID_BYTE_ONE, CODE_SMALL, CODE_MEDIUM, CODE_LARGE, ID_BYTE_THREE, PAT_RESET_CRC[0],
      PAT_DONE[0], PAT_PREAMBLE[2], PAT_PREAMBLE[3]};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   int          mismatch_count;
   int          bytes_outstanding;
   int          rsp_hold = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   logic [7:0]  stream_q [$];

   always #5 clock = ~clock;

   bitstream_id_patch_crc_fix u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   bitstream_scan_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .rsp_tlast         (rsp_tlast),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // stall the response side at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold <= rsp_calm ? 0 : pick_gap();
      end
   end

   function automatic void add_quad(input logic [0:3][7:0] q);
      for (int i = 0; i < 4; i++) stream_q.push_back(q[i]);
   endfunction

   function automatic void add_random(input int n);
      for (int i = 0; i < n; i++) stream_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_noise(input int n, input int ff_pct);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < ff_pct) stream_q.push_back(BYTE_ONES);
         else if (r[0]) stream_q.push_back(8'($urandom_range(0, 255)));
         else stream_q.push_back(HOT_BYTES[$urandom_range(0, 15)]);
      end
   endfunction

   function automatic void add_id(input bit good);
      logic [0:3][7:0] tail;
      logic [7:0]      fam;
      fam = $urandom_range(0, 1) ? FAMILY_LONG : FAMILY_PATCH;
      case ($urandom_range(0, 2))
         0:       tail = {fam, ID_BYTE_ONE, CODE_SMALL, ID_BYTE_THREE};
         1:       tail = {fam, ID_BYTE_ONE, CODE_MEDIUM, ID_BYTE_THREE};
         default: tail = {fam, ID_BYTE_ONE, CODE_LARGE, ID_BYTE_THREE};
      endcase
      if (!good) tail[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      add_quad(PAT_VERIFY_ID);
      add_quad(tail);
   endfunction

   function automatic void build_stream(input int kind);
      int          size;
      int          len;
      logic [15:0] total;
      logic [7:0]  code;
      logic [7:0]  fam;
      stream_q.delete();
      if (kind <= 5) begin
         size = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1;
         case (size)
            1: begin
               total = 16'd7562;
               len = 74;
               code = CODE_SMALL;
            end
            2: begin
               total = 16'd9470;
               len = 106;
               code = CODE_MEDIUM;
            end
            default: begin
               total = 16'd13294;
               len = 142;
               code = CODE_LARGE;
            end
         endcase
         fam = $urandom_range(0, 2) ? FAMILY_LONG : FAMILY_PATCH;
         add_noise($urandom_range(0, 3), 20);
         add_quad(PAT_PREAMBLE[0:3]);
         add_quad(PAT_PREAMBLE[4:7]);
         add_noise($urandom_range(0, 2), 0);
         add_quad(PAT_RESET_CRC);
         add_quad(PAT_VERIFY_ID);
         add_quad({fam, ID_BYTE_ONE, code, ID_BYTE_THREE});
         add_quad({CMD_INCR, CMD_INCR_ARG, total[15:8], total[7:0]});
         add_random(len + 2);
         stream_q.push_back(BYTE_ONES);
         if ($urandom_range(0, 1)) begin
            add_quad(PAT_DONE[0:3]);
            add_quad(PAT_DONE[4:7]);
         end
         add_noise($urandom_range(1, 5), 20);
      end else if (kind <= 7) begin
         // frame size zero: the CRC skips two of every three bytes once the id is known
         if ($urandom_range(0, 1)) begin
            add_quad(PAT_PREAMBLE[0:3]);
            add_quad(PAT_PREAMBLE[4:7]);
         end
         add_quad({CMD_INCR, CMD_INCR_ARG, 8'h00, 8'h00});
         add_quad(PAT_RESET_CRC);
         add_id(1'b1);
         add_noise($urandom_range(8, 16), 45);
         if ($urandom_range(0, 2) == 0) begin
            add_quad(PAT_DONE[0:3]);
            add_quad(PAT_DONE[4:7]);
            add_noise($urandom_range(1, 6), 30);
         end
      end else if (kind == 8) begin
         add_quad(PAT_PREAMBLE[0:3]);
         add_quad(PAT_PREAMBLE[4:7]);
         add_id(1'b0);
         add_noise($urandom_range(1, 10), 30);
      end else begin
         add_noise($urandom_range(1, 20), 15);
      end
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_stream();
      req_calm = $urandom_range(0, 3) == 0;
      rsp_calm = $urandom_range(0, 3) == 0;
      foreach (stream_q[i]) push_byte(stream_q[i], i == stream_q.size() - 1);
      req_tvalid <= 1'b0;
      stream_q.delete();
   endtask

   task automatic settle();
      while (bytes_outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_patch(input logic value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_patch(1'b1);

      // lone byte, id check ahead of the preamble, early increment then bad size code
      stream_q = '{BYTE_ONES};
      send_stream();
      add_quad(PAT_VERIFY_ID);
      add_quad({FAMILY_LONG, ID_BYTE_ONE, CODE_SMALL, ID_BYTE_THREE});
      add_quad(32'h0);
      send_stream();
      add_quad({CMD_INCR, CMD_INCR_ARG, 8'h00, 8'h00});
      add_quad(PAT_VERIFY_ID);
      add_quad({FAMILY_PATCH, ID_BYTE_ONE, 8'h55, ID_BYTE_THREE});
      send_stream();

      // full frame with patching, then one short run of random kind
      settle();
      set_patch(1'b1);
      build_stream(0);
      send_stream();
      settle();
      set_patch(1'($urandom_range(0, 1)));
      build_stream($urandom_range(6, 9));
      send_stream();

      settle();
      if (mismatch_count == 0 && bytes_outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
